@@ hw/rtl/mic_pkg.sv @@
`timescale 1ns / 1ps
// Package for the microcode image checker: payload and queue entry types,
// header word positions, size constants, error and register codes. No dependencies.
package mic_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   localparam int TOTAL_ALIGN_BITS = 10;
   localparam int DATA_ALIGN_BITS = 2;

   localparam logic [29:0] IDX_REVISION = 30'd1;
   localparam logic [29:0] IDX_SIGNATURE = 30'd3;
   localparam logic [29:0] IDX_LOADER = 30'd5;
   localparam logic [29:0] IDX_PLATFORM = 30'd6;
   localparam logic [29:0] IDX_DATA_SIZE = 30'd7;
   localparam logic [29:0] IDX_TOTAL_SIZE = 30'd8;
   localparam logic [29:0] IDX_DERIVE = 30'd9;
   localparam logic [29:0] IDX_DERIVE_TABLE = 30'd10;
   localparam logic [29:0] IDX_LAST_HEADER = 30'd11;
   localparam logic [29:0] IDX_FIRST_BODY = 30'd12;

   localparam logic [31:0] HDR_WORDS = 32'd12;
   localparam logic [31:0] HDR_BYTES = 32'd48;
   localparam logic [31:0] LEGACY_DATA = 32'd2000;
   localparam logic [31:0] LEGACY_TOTAL = 32'd2048;
   localparam logic [31:0] TABLE_HDR_BYTES = 32'd20;
   localparam logic [31:0] LOADER_REV = 32'd1;
   localparam logic [2:0] TABLE_HDR_WORDS = 3'd5;
   localparam logic [1:0] ENTRY_LAST_PHASE = 2'd2;

   localparam logic [2:0] ERR_OK = 3'd0;
   localparam logic [2:0] ERR_LOADER = 3'd1;
   localparam logic [2:0] ERR_TOTAL_ALIGN = 3'd2;
   localparam logic [2:0] ERR_DATA_ALIGN = 3'd3;
   localparam logic [2:0] ERR_SUM = 3'd4;
   localparam logic [2:0] ERR_EXT_SHORT = 3'd5;
   localparam logic [2:0] ERR_EXT_SIZE = 3'd6;
   localparam logic [2:0] ERR_EXT_SUM = 3'd7;

   localparam logic [1:0] CSR_CPU_SIGNATURE = 2'd0;
   localparam logic [1:0] CSR_PLATFORM_MASK = 2'd1;
   localparam logic [1:0] CSR_CURRENT_REVISION = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE      = 3'd0,
      OP_REVISION  = 3'd1,
      OP_SIGNATURE = 3'd2,
      OP_LOADER    = 3'd3,
      OP_PLATFORM  = 3'd4
   } mic_op_type;

   typedef struct packed {
      logic [31:0] image_word;
      logic        first_of_image;
   } mic_req_type;

   typedef struct packed {
      logic [2:0]         error_code;
      logic               matched;
      logic signed [31:0] image_revision;
      logic               is_newer;
   } mic_rsp_type;

   typedef struct packed {
      logic [31:0]        cpu_signature;
      logic [7:0]         platform_mask;
      logic signed [31:0] current_revision;
   } mic_cfg_type;

   typedef struct packed {
      logic [31:0] word;
      mic_op_type  op;
      logic        start;
      logic        in_tbl;
      logic        tsize_bad;
      logic        last;
      logic        short_end;
      logic        total_mis;
      logic        data_mis;
      logic        no_tbl;
      logic        tbl_short;
   } mic_entry_type;

   function automatic logic plat_match(logic [31:0] flags, logic [7:0] mask);
      return ((flags == 32'd0) && (mask == 8'd0)) || ((flags[7:0] & mask) != 8'd0);
   endfunction

endpackage

@@ hw/rtl/mic_queue.sv @@
`timescale 1ns / 1ps
// Short queue of classified image words between the parser front and the checker back.
// Depends on mic_pkg.
module mic_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mic_pkg::mic_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output mic_pkg::mic_entry_type head_entry
);

   mic_pkg::mic_entry_type             mem_ff [mic_pkg::QUEUE_DEPTH];
   logic [mic_pkg::QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mic_pkg::QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mic_pkg::QUEUE_AW:0]         count_ff, count_in;

   assign full = count_ff == (mic_pkg::QUEUE_AW + 1)'(mic_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/mic_front.sv @@
`timescale 1ns / 1ps
// Parser front: tracks the word position in the image, captures the sizes and
// classifies each word for the checker back. Depends on mic_pkg.
module mic_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mic_pkg::mic_req_type   req_data,
   input  logic                   q_full,
   output logic                   push,
   output mic_pkg::mic_entry_type push_entry
);

   logic [29:0] idx_ff, idx_in, cur_idx;
   logic [31:0] data_ff, data_in;
   logic [31:0] image_ff, image_in;
   logic        short_ff, short_in;
   logic [31:0] extra_ff, extra_in;
   logic [31:0] tstart_ff, tstart_in;
   logic [31:0] last_ff, last_in;
   logic        tbl_ok_ff, tbl_ok_in;
   logic [31:0] extra_m20_ff, extra_m20_in;
   logic        no_tbl_ff, no_tbl_in;
   logic [2:0]  tpos_ff, tpos_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] w;
   logic [35:0] entry_bytes;
   logic        in_tbl, short_end, normal_end;

   assign req_ready = !q_full;
   assign push = req_valid && req_ready;
   assign w = req_data.image_word;
   assign cur_idx = req_data.first_of_image ? '0 : idx_ff;
   assign entry_bytes = {1'b0, w, 3'b000} + {2'b00, w, 2'b00};
   assign in_tbl = (cur_idx >= mic_pkg::IDX_FIRST_BODY) && tbl_ok_ff
                   && ({2'b00, cur_idx} >= tstart_ff);
   assign short_end = (cur_idx == mic_pkg::IDX_LAST_HEADER) && short_ff;
   assign normal_end = (cur_idx >= mic_pkg::IDX_LAST_HEADER) && ({2'b00, cur_idx} == last_ff);

   always_comb begin
      push_entry = '0;
      push_entry.word = w;
      push_entry.op = mic_pkg::OP_NONE;
      push_entry.start = cur_idx == '0;
      push_entry.in_tbl = in_tbl;
      push_entry.last = short_end || normal_end;
      push_entry.short_end = short_end;
      push_entry.total_mis = image_ff[mic_pkg::TOTAL_ALIGN_BITS-1:0] != '0;
      push_entry.data_mis = data_ff[mic_pkg::DATA_ALIGN_BITS-1:0] != '0;
      push_entry.no_tbl = no_tbl_ff;
      push_entry.tbl_short = !tbl_ok_ff;

      idx_in = idx_ff;
      data_in = data_ff;
      image_in = image_ff;
      short_in = short_ff;
      extra_in = extra_ff;
      tstart_in = tstart_ff;
      last_in = last_ff;
      tbl_ok_in = tbl_ok_ff;
      extra_m20_in = extra_m20_ff;
      no_tbl_in = no_tbl_ff;
      tpos_in = tpos_ff;
      phase_in = phase_ff;

      case (cur_idx)
         mic_pkg::IDX_REVISION: push_entry.op = mic_pkg::OP_REVISION;
         mic_pkg::IDX_SIGNATURE: push_entry.op = mic_pkg::OP_SIGNATURE;
         mic_pkg::IDX_LOADER: push_entry.op = mic_pkg::OP_LOADER;
         mic_pkg::IDX_PLATFORM: push_entry.op = mic_pkg::OP_PLATFORM;
         default: push_entry.op = mic_pkg::OP_NONE;
      endcase

      if (in_tbl) begin
         if (tpos_ff == '0) begin
            push_entry.tsize_bad = entry_bytes != {4'b0000, extra_m20_ff};
         end
         if (tpos_ff != mic_pkg::TABLE_HDR_WORDS) begin
            tpos_in = tpos_ff + 1'b1;
         end else begin
            case (phase_ff)
               2'd0: push_entry.op = mic_pkg::OP_SIGNATURE;
               2'd1: push_entry.op = mic_pkg::OP_PLATFORM;
               default: push_entry.op = mic_pkg::OP_NONE;
            endcase
            phase_in = (phase_ff == mic_pkg::ENTRY_LAST_PHASE) ? 2'd0 : phase_ff + 1'b1;
         end
      end

      if (cur_idx == '0) begin
         tpos_in = '0;
         phase_in = '0;
      end

      case (cur_idx)
         mic_pkg::IDX_DATA_SIZE: data_in = w;
         mic_pkg::IDX_TOTAL_SIZE: begin
            if (data_ff == '0) begin
               data_in = mic_pkg::LEGACY_DATA;
               image_in = mic_pkg::LEGACY_TOTAL;
            end else begin
               image_in = w;
            end
         end
         mic_pkg::IDX_DERIVE: begin
            short_in = {1'b0, image_ff} < ({1'b0, data_ff} + {1'b0, mic_pkg::HDR_BYTES});
            extra_in = image_ff - data_ff - mic_pkg::HDR_BYTES;
            tstart_in = mic_pkg::HDR_WORDS + {2'b00, data_ff[31:2]};
            last_in = {2'b00, image_ff[31:2]} - 32'd1;
         end
         mic_pkg::IDX_DERIVE_TABLE: begin
            tbl_ok_in = extra_ff >= mic_pkg::TABLE_HDR_BYTES;
            extra_m20_in = extra_ff - mic_pkg::TABLE_HDR_BYTES;
            no_tbl_in = extra_ff == '0;
         end
         default: ;
      endcase

      idx_in = push_entry.last ? '0 : cur_idx + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         tpos_ff <= '0;
         phase_ff <= '0;
      end else if (push) begin
         idx_ff <= idx_in;
         tpos_ff <= tpos_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= data_in;
         image_ff <= image_in;
         short_ff <= short_in;
         extra_ff <= extra_in;
         tstart_ff <= tstart_in;
         last_ff <= last_in;
         tbl_ok_ff <= tbl_ok_in;
         extra_m20_ff <= extra_m20_in;
         no_tbl_ff <= no_tbl_in;
      end
   end

endmodule

@@ hw/rtl/mic_back.sv @@
`timescale 1ns / 1ps
// Checker back: keeps the image and table sums, the signature match and the
// error flags, and registers one result per finished image. Depends on mic_pkg.
module mic_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  mic_pkg::mic_entry_type head_entry,
   output logic                   pop,
   input  mic_pkg::mic_cfg_type   cfg,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mic_pkg::mic_rsp_type   rsp_data
);

   logic [31:0]          sum_ff, sum_in;
   logic [31:0]          tsum_ff, tsum_in;
   logic [31:0]          rev_ff, rev_in;
   logic [31:0]          sig_ff, sig_in;
   logic                 loader_ff, loader_in;
   logic                 match_ff, match_in;
   logic                 tsize_ff, tsize_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mic_pkg::mic_rsp_type rsp_data_ff, rsp_data_in;
   logic [31:0]          w;
   logic [2:0]           early, err;

   assign w = head_entry.word;
   assign pop = head_valid && (!head_entry.last || !rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      sum_in = (head_entry.start ? 32'd0 : sum_ff) + w;
      tsum_in = head_entry.start ? 32'd0 : tsum_ff;
      if (head_entry.in_tbl) begin
         tsum_in = tsum_in + w;
      end
      rev_in = head_entry.start ? 32'd0 : rev_ff;
      sig_in = head_entry.start ? 32'd0 : sig_ff;
      loader_in = head_entry.start ? 1'b0 : loader_ff;
      match_in = head_entry.start ? 1'b0 : match_ff;
      tsize_in = (head_entry.start ? 1'b0 : tsize_ff) || head_entry.tsize_bad;

      case (head_entry.op)
         mic_pkg::OP_REVISION: rev_in = w;
         mic_pkg::OP_SIGNATURE: sig_in = w;
         mic_pkg::OP_LOADER: loader_in = loader_in || (w != mic_pkg::LOADER_REV);
         mic_pkg::OP_PLATFORM: begin
            if ((sig_in == cfg.cpu_signature) && mic_pkg::plat_match(w, cfg.platform_mask)) begin
               match_in = 1'b1;
            end
         end
         default: ;
      endcase

      if (loader_in) begin
         early = mic_pkg::ERR_LOADER;
      end else if (head_entry.total_mis) begin
         early = mic_pkg::ERR_TOTAL_ALIGN;
      end else if (head_entry.data_mis) begin
         early = mic_pkg::ERR_DATA_ALIGN;
      end else begin
         early = mic_pkg::ERR_OK;
      end

      if (early != mic_pkg::ERR_OK) begin
         err = early;
      end else if (head_entry.short_end) begin
         err = mic_pkg::ERR_EXT_SIZE;
      end else if (sum_in != 32'd0) begin
         err = mic_pkg::ERR_SUM;
      end else if (head_entry.no_tbl) begin
         err = mic_pkg::ERR_OK;
      end else if (head_entry.tbl_short) begin
         err = mic_pkg::ERR_EXT_SHORT;
      end else if (tsize_in) begin
         err = mic_pkg::ERR_EXT_SIZE;
      end else if (tsum_in != 32'd0) begin
         err = mic_pkg::ERR_EXT_SUM;
      end else begin
         err = mic_pkg::ERR_OK;
      end

      rsp_data_in.error_code = err;
      rsp_data_in.matched = (err == mic_pkg::ERR_OK) && match_in;
      rsp_data_in.image_revision = $signed(rev_in);
      rsp_data_in.is_newer = $signed(rev_in) > cfg.current_revision;

      rsp_valid_in = rsp_valid_ff;
      if (pop && head_entry.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         sum_ff <= sum_in;
         tsum_ff <= tsum_in;
         rev_ff <= rev_in;
         sig_ff <= sig_in;
         loader_ff <= loader_in;
         match_ff <= match_in;
         tsize_ff <= tsize_in;
      end
      if (pop && head_entry.last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

@@ hw/rtl/microcode_image_checker_core.sv @@
`timescale 1ns / 1ps
// Top level of the microcode image checker: register port, parser front,
// queue and checker back. Depends on mic_pkg, mic_front, mic_queue and mic_back.

// The checker takes one image word per clock for as long as its four-entry queue
// has room, and it emits one result per image in the cycle after the image's last
// word leaves the queue; that word leaves the queue once it is at the head and the
// result register is free. Images follow each other with no gap. The queue lets
// the parser keep accepting words while a finished result waits on rsp_ready;
// words stop being taken only once the queue is full behind that result. The
// three registers are written through the csr port, which never stalls, and
// should be changed only while no image is in flight.
module microcode_image_checker_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mic_pkg::mic_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mic_pkg::mic_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data
);

   mic_pkg::mic_cfg_type   cfg_ff, cfg_in;
   mic_pkg::mic_entry_type push_entry, head_entry;
   logic                   push, pop, q_full, head_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            mic_pkg::CSR_CPU_SIGNATURE: cfg_in.cpu_signature = csr_data;
            mic_pkg::CSR_PLATFORM_MASK: cfg_in.platform_mask = csr_data[7:0];
            mic_pkg::CSR_CURRENT_REVISION: cfg_in.current_revision = $signed(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mic_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   mic_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   mic_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .cfg        (cfg_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

@@ hw/rtl/mic_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the microcode image checker, bound to the top level.
// Depends on mic_pkg and microcode_image_checker_core.
module mic_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input mic_pkg::mic_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input mic_pkg::mic_rsp_type rsp_data,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [1:0]           csr_index,
   input logic [31:0]          csr_data
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready && csr_ready)
      else $error("Checker is not empty and ready after reset.");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result changed or was dropped.");

   a_match_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.error_code != mic_pkg::ERR_OK) |-> !rsp_data.matched)
      else $error("Failed image reported as matched.");

   a_rsp_only_after_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready || (req_valid && req_ready), 1)
                           || $past(req_valid && req_ready, 2)
                           || $past(!req_ready, 2))
      else $error("Result appeared with no buffered request.");

endmodule

bind microcode_image_checker_core mic_checker u_mic_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for microcode_image_checker_core: streams generated update
// images, predicts each image verdict and compares it field by field. Depends on mic_pkg.
module tb_top;
   import mic_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int FLAW_SUM = 1;
   localparam int FLAW_TABLE_SUM = 2;
   localparam int FLAW_COUNT = 4;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   mic_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   mic_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   logic [31:0]        cfg_signature;
   logic [7:0]         cfg_platform;
   logic signed [31:0] cfg_revision;

   logic [29:0]        img_pos;
   logic [31:0]        img_sum;
   logic [31:0]        tbl_sum;
   logic [31:0]        data_len;
   logic [31:0]        total_len;
   logic signed [31:0] img_rev;
   logic [31:0]        img_sig;
   logic [31:0]        entry_total;
   logic [31:0]        entry_sig;
   logic               loader_bad;
   logic               match_seen;
   logic               tbl_size_bad;

   mic_rsp_type expected_verdicts[$];
   logic [31:0] image_words[$];

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int          fail_count;
   int          verdicts_checked;
   int          words_sent;
   int          phase_verdicts;
   int          csr_writes;
   int          match_count;
   logic [7:0]  codes_seen;

   microcode_image_checker_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   function automatic logic platform_hit(input logic [31:0] flags, input logic [7:0] mask);
      return ((flags & {24'd0, mask}) != 32'd0) || (flags == 32'd0 && mask == 8'd0);
   endfunction

   function automatic logic short_image();
      return {32'd0, total_len} < {32'd0, data_len} + {32'd0, HDR_BYTES};
   endfunction

   function automatic logic [2:0] early_code();
      if (loader_bad) return ERR_LOADER;
      if (total_len[TOTAL_ALIGN_BITS-1:0] != '0) return ERR_TOTAL_ALIGN;
      if (data_len[DATA_ALIGN_BITS-1:0] != '0) return ERR_DATA_ALIGN;
      return ERR_OK;
   endfunction

   function automatic logic lead_flag();
      if (img_pos != 30'd0) return 1'b1;
      return $urandom_range(0, 7) != 0;
   endfunction

   function automatic logic [31:0] pick_signature();
      return $urandom_range(0, 1) ? cfg_signature : $urandom;
   endfunction

   function automatic logic [31:0] pick_platform();
      case ($urandom_range(0, 2))
         0: return {24'd0, cfg_platform};
         1: return $urandom;
         default: return 32'd0;
      endcase
   endfunction

   task automatic clear_image_state();
      img_pos = '0;
      img_sum = '0;
      tbl_sum = '0;
      data_len = '0;
      total_len = '0;
      img_rev = '0;
      img_sig = '0;
      entry_total = '0;
      entry_sig = '0;
      loader_bad = 1'b0;
      match_seen = 1'b0;
      tbl_size_bad = 1'b0;
   endtask

   task automatic track_image_word(input logic [31:0] w, input logic lead);
      logic [29:0] idx;
      logic [31:0] tstart;
      logic [31:0] toff;
      logic [63:0] spare;
      logic [2:0]  code;
      logic        finished;
      mic_rsp_type verdict;
      if (lead) clear_image_state();
      idx = img_pos;
      finished = 1'b0;
      code = ERR_OK;
      img_sum = img_sum + w;
      case (idx)
         IDX_REVISION: img_rev = w;
         IDX_SIGNATURE: img_sig = w;
         IDX_LOADER: begin
            if (w != LOADER_REV) loader_bad = 1'b1;
         end
         IDX_PLATFORM: begin
            if (img_sig == cfg_signature && platform_hit(w, cfg_platform)) match_seen = 1'b1;
         end
         IDX_DATA_SIZE: data_len = w;
         IDX_TOTAL_SIZE: begin
            if (data_len == 32'd0) begin
               data_len = LEGACY_DATA;
               total_len = LEGACY_TOTAL;
            end else begin
               total_len = w;
            end
         end
         default: ;
      endcase

      if ({2'd0, idx} >= HDR_WORDS && !short_image()) begin
         tstart = HDR_WORDS + (data_len >> 2);
         spare = {32'd0, total_len} - {32'd0, data_len} - {32'd0, HDR_BYTES};
         if (spare >= {32'd0, TABLE_HDR_BYTES} && {2'd0, idx} >= tstart) begin
            toff = {2'd0, idx} - tstart;
            tbl_sum = tbl_sum + w;
            if (toff == 32'd0) begin
               entry_total = w;
               if (spare != {32'd0, TABLE_HDR_BYTES} + 64'd12 * {32'd0, w}) tbl_size_bad = 1'b1;
            end else if (toff >= {29'd0, TABLE_HDR_WORDS}) begin
               case ((toff - {29'd0, TABLE_HDR_WORDS}) % 32'd3)
                  32'd0: entry_sig = w;
                  32'd1: begin
                     if (entry_sig == cfg_signature && platform_hit(w, cfg_platform))
                        match_seen = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
      end

      if ({2'd0, idx} == HDR_WORDS - 32'd1 && short_image()) begin
         code = early_code();
         if (code == ERR_OK) code = ERR_EXT_SIZE;
         finished = 1'b1;
      end else if ({2'd0, idx} >= HDR_WORDS - 32'd1 &&
                   {2'd0, idx} == (total_len >> 2) - 32'd1) begin
         spare = {32'd0, total_len} - {32'd0, data_len} - {32'd0, HDR_BYTES};
         code = early_code();
         if (code == ERR_OK) begin
            if (img_sum != 32'd0) code = ERR_SUM;
            else if (spare == 64'd0) code = ERR_OK;
            else if (spare < {32'd0, TABLE_HDR_BYTES}) code = ERR_EXT_SHORT;
            else if (tbl_size_bad) code = ERR_EXT_SIZE;
            else if (tbl_sum != 32'd0) code = ERR_EXT_SUM;
         end
         finished = 1'b1;
      end

      if (finished) begin
         verdict.error_code = code;
         verdict.matched = (code == ERR_OK) && match_seen;
         verdict.image_revision = img_rev;
         verdict.is_newer = img_rev > cfg_revision;
         expected_verdicts.push_back(verdict);
         phase_verdicts++;
         clear_image_state();
      end else begin
         img_pos = idx + 30'd1;
      end
   endtask

   task automatic check_verdict(input mic_rsp_type got);
      mic_rsp_type want;
      if (expected_verdicts.size() == 0) begin
         $error("verdict with none expected: error_code %0d image_revision %0d",
                got.error_code, got.image_revision);
         fail_count++;
      end else begin
         want = expected_verdicts.pop_front();
         if (got.error_code !== want.error_code) begin
            $error("error_code expected %0d actual %0d", want.error_code, got.error_code);
            fail_count++;
         end
         if (got.matched !== want.matched) begin
            $error("matched expected %0d actual %0d", want.matched, got.matched);
            fail_count++;
         end
         if (got.image_revision !== want.image_revision) begin
            $error("image_revision expected %0d actual %0d",
                   want.image_revision, got.image_revision);
            fail_count++;
         end
         if (got.is_newer !== want.is_newer) begin
            $error("is_newer expected %0d actual %0d", want.is_newer, got.is_newer);
            fail_count++;
         end
         verdicts_checked++;
         codes_seen[want.error_code] = 1'b1;
         if (want.matched) match_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_verdict(rsp_data);
   end

   task automatic send_word(input logic [31:0] w, input logic lead);
      mic_req_type item;
      item.image_word = w;
      item.first_of_image = lead;
      @(negedge clock);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_image_word(w, lead);
      words_sent++;
   endtask

   task automatic send_image(input int count, input logic lead);
      int i;
      for (i = 0; i < count; i++) send_word(image_words[i], (i == 0) ? lead : 1'b0);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_CPU_SIGNATURE: cfg_signature = value;
         CSR_PLATFORM_MASK: cfg_platform = value[7:0];
         CSR_CURRENT_REVISION: cfg_revision = value;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_processor(input logic [31:0] sig, input logic [7:0] mask,
                                input logic [31:0] rev);
      wait_quiet();
      write_csr(CSR_CPU_SIGNATURE, sig);
      write_csr(CSR_PLATFORM_MASK, {24'd0, mask});
      write_csr(CSR_CURRENT_REVISION, rev);
   endtask

   // Lays out header, data, optional extended table, padding; fixes sums unless short.
   task automatic build_image(input logic [31:0] data_field, input logic [31:0] total_field,
                              input int n_tbl, input int flaws, input logic [31:0] loader,
                              input logic [31:0] sig, input logic [31:0] plat,
                              input logic [31:0] rev, input int ext_hit);
      logic [31:0] dsz;
      logic [31:0] tsz;
      logic [31:0] acc;
      logic [63:0] spare;
      logic        is_short;
      int          nwords;
      int          tb;
      int          base;
      int          e;
      int          i;
      dsz = (data_field == 32'd0) ? LEGACY_DATA : data_field;
      tsz = (data_field == 32'd0) ? LEGACY_TOTAL : total_field;
      is_short = {32'd0, tsz} < {32'd0, dsz} + {32'd0, HDR_BYTES};
      nwords = is_short ? HDR_WORDS : (tsz >> 2);
      image_words.delete();
      repeat (nwords) image_words.push_back($urandom);
      image_words[IDX_REVISION] = rev;
      image_words[IDX_SIGNATURE] = sig;
      image_words[IDX_LOADER] = loader;
      image_words[IDX_PLATFORM] = plat;
      image_words[IDX_DATA_SIZE] = data_field;
      image_words[IDX_TOTAL_SIZE] = total_field;
      if (!is_short) begin
         spare = {32'd0, tsz} - {32'd0, dsz} - {32'd0, HDR_BYTES};
         if (spare >= {32'd0, TABLE_HDR_BYTES}) begin
            tb = HDR_WORDS + (dsz >> 2);
            image_words[tb] = n_tbl + (((flaws & FLAW_COUNT) != 0) ? 1 : 0);
            for (e = 0; e < n_tbl; e++) begin
               base = tb + TABLE_HDR_WORDS + 3 * e;
               if (base + 1 < nwords) begin
                  image_words[base] = (e == ext_hit) ? cfg_signature : $urandom;
                  image_words[base + 1] = (e == ext_hit) ? {24'd0, cfg_platform} : $urandom;
               end
            end
            acc = '0;
            for (i = tb; i < nwords; i++) acc = acc + image_words[i];
            image_words[tb + 1] = image_words[tb + 1] - acc;
            if ((flaws & FLAW_TABLE_SUM) != 0) image_words[tb + 1] = image_words[tb + 1] + 32'd1;
         end
         acc = '0;
         for (i = 0; i < nwords; i++) acc = acc + image_words[i];
         image_words[4] = image_words[4] - acc;
         if ((flaws & FLAW_SUM) != 0) image_words[4] = image_words[4] + 32'd1;
      end
   endtask

   task automatic check_image(input logic [31:0] data_field, input logic [31:0] total_field,
                              input int n_tbl, input int flaws, input logic [31:0] loader,
                              input logic [31:0] sig, input logic [31:0] plat,
                              input logic [31:0] rev, input int ext_hit);
      build_image(data_field, total_field, n_tbl, flaws, loader, sig, plat, rev, ext_hit);
      send_image(image_words.size(), lead_flag());
   endtask

   task automatic well_formed_image();
      int          n;
      int          flaws;
      int          hit;
      logic [31:0] tot;
      logic [31:0] d;
      logic [31:0] loader;
      n = $urandom_range(0, 5);
      tot = ($urandom_range(0, 7) == 0) ? LEGACY_TOTAL : 32'd1024;
      d = $urandom_range(0, 1) ? tot - HDR_BYTES - TABLE_HDR_BYTES - 12 * n : tot - HDR_BYTES;
      flaws = ($urandom_range(0, 3) == 0) ? (1 << $urandom_range(0, 2)) : 0;
      loader = ($urandom_range(0, 7) == 0) ? $urandom : LOADER_REV;
      hit = (n > 0 && $urandom_range(0, 1)) ? $urandom_range(0, n - 1) : -1;
      build_image(d, tot, n, flaws, loader, pick_signature(), pick_platform(), $urandom, hit);
   endtask

   task automatic random_image();
      logic [31:0] d;
      logic [31:0] t;
      logic [31:0] loader;
      loader = ($urandom_range(0, 3) == 0) ? $urandom : LOADER_REV;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            well_formed_image();
            send_image(image_words.size(), lead_flag());
         end
         3: begin
            check_image(32'd0, $urandom, 0, ($urandom_range(0, 3) == 0) ? FLAW_SUM : 0,
                        loader, pick_signature(), pick_platform(), $urandom, -1);
         end
         4, 5: begin
            if ($urandom_range(0, 3) == 0) begin
               d = $urandom | 32'h8000_0000;
               t = $urandom & 32'h7FFF_FFFF;
            end else begin
               d = $urandom_range(1, 3000);
               t = $urandom_range(0, d + 47);
            end
            if ($urandom_range(0, 1)) t = t & ~32'h3FF;
            check_image(d, t, 0, 0, loader, pick_signature(), pick_platform(), $urandom, -1);
         end
         6, 7: begin
            d = 4 * $urandom_range(1, 30) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            t = d + HDR_BYTES + $urandom_range(0, 120);
            if (t[TOTAL_ALIGN_BITS-1:0] == '0) t = t + 32'd4;
            check_image(d, t, 0, 0, loader, pick_signature(), pick_platform(), $urandom, -1);
         end
         8: begin
            well_formed_image();
            send_image($urandom_range(1, image_words.size() - 1), lead_flag());
         end
         default: begin
            repeat ($urandom_range(1, 24)) send_word($urandom, $urandom_range(0, 7) == 0);
         end
      endcase
   endtask

   task automatic random_phase(input int unsigned idle, input int unsigned stall,
                               input logic [31:0] sig, input logic [7:0] mask,
                               input logic [31:0] rev);
      int start_words;
      set_processor(sig, mask, rev);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      start_words = words_sent;
      phase_verdicts = 0;
      while (words_sent - start_words < 440 || phase_verdicts < 10) random_image();
   endtask

   task automatic test_header_checks();
      set_processor(32'h0009_06EA, 8'h02, 32'h0000_00F0);
      check_image(32'd100, 32'd0, 0, 0, 32'd2, cfg_signature, 32'd2, 32'h10, -1);
      check_image(32'd4, 32'd64, 0, 0, LOADER_REV, cfg_signature, 32'd2, 32'h11, -1);
      check_image(32'd5, 32'd0, 0, 0, LOADER_REV, cfg_signature, 32'd2, 32'h12, -1);
      check_image(32'd976, 32'd0, 0, 0, LOADER_REV, cfg_signature, 32'd2, 32'h13, -1);
      check_image(32'hFFFF_FFFC, 32'hFFFF_FC00, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, -1);
   endtask

   task automatic test_body_checks();
      check_image(32'd976, 32'd1024, 0, 0, LOADER_REV, cfg_signature, 32'd2, 32'h200, -1);
      check_image(32'd976, 32'd1024, 0, FLAW_SUM, LOADER_REV, cfg_signature, 32'd2, 32'h201, -1);
      check_image(32'd972, 32'd1024, 0, 0, LOADER_REV, cfg_signature, 32'd2, 32'h202, -1);
      check_image(32'd956, 32'd1024, 0, 0, LOADER_REV, cfg_signature, 32'd6, 32'h203, -1);
      check_image(32'd932, 32'd1024, 2, 0, LOADER_REV, $urandom, 32'd2, 32'h204, -1);
      check_image(32'd932, 32'd1024, 2, FLAW_COUNT, LOADER_REV, cfg_signature, 32'd2,
                  32'h205, -1);
      check_image(32'd932, 32'd1024, 2, FLAW_TABLE_SUM, LOADER_REV, cfg_signature, 32'd2,
                  32'h206, -1);
   endtask

   task automatic test_signature_matching();
      check_image(32'd976, 32'd1024, 0, 0, LOADER_REV, ~cfg_signature, 32'd2, 32'h300, -1);
      check_image(32'd976, 32'd1024, 0, 0, LOADER_REV, cfg_signature, 32'hFD, 32'h301, -1);
      check_image(32'd920, 32'd1024, 3, 0, LOADER_REV, ~cfg_signature, 32'd0, 32'h302, 2);
      check_image(32'd0, 32'hFFFF_FFFF, 0, 0, LOADER_REV, cfg_signature, 32'd2, 32'h303, -1);
   endtask

   task automatic test_resync();
      build_image(32'd976, 32'd1024, 0, 0, LOADER_REV, cfg_signature, 32'd2, 32'h400, -1);
      send_image(100, 1'b1);
      check_image(32'd976, 32'd1024, 0, 0, LOADER_REV, cfg_signature, 32'd2, 32'h401, -1);
      build_image(32'd8, 32'd0, 0, 0, LOADER_REV, cfg_signature, 32'd2, 32'h402, -1);
      send_image(image_words.size(), 1'b0);
   endtask

   task automatic test_revision_compare();
      set_processor(32'hFFFF_FFFF, 8'h00, 32'h7FFF_FFFF);
      check_image(32'd8, 32'd0, 0, 0, LOADER_REV, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, -1);
      check_image(32'd8, 32'd0, 0, 0, LOADER_REV, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, -1);
      check_image(32'd976, 32'd1024, 0, 0, LOADER_REV, 32'hFFFF_FFFF, 32'd0, 32'h1, -1);
      set_processor(32'h0000_0000, 8'hFF, 32'h8000_0000);
      check_image(32'd8, 32'd0, 0, 0, LOADER_REV, 32'd0, 32'd0, 32'h8000_0000, -1);
      check_image(32'd8, 32'd0, 0, 0, LOADER_REV, 32'd0, 32'd0, 32'h8000_0001, -1);
   endtask

   task automatic test_random_traffic();
      random_phase(0, 0, $urandom, 8'd1 << $urandom_range(0, 7), $urandom);
      random_phase(78, 0, 32'd0, 8'd0, 32'h8000_0000);
      random_phase(0, 78, 32'hFFFF_FFFF, 8'h80, 32'h7FFF_FFFF);
      random_phase(33, 33, $urandom, $urandom_range(0, 255), $urandom);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fail_count = 0;
      verdicts_checked = 0;
      words_sent = 0;
      phase_verdicts = 0;
      csr_writes = 0;
      match_count = 0;
      codes_seen = '0;
      cfg_signature = '0;
      cfg_platform = '0;
      cfg_revision = '0;
      clear_image_state();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_header_checks();
      test_body_checks();
      test_signature_matching();
      test_resync();
      test_revision_compare();
      test_random_traffic();
      wait_quiet();

      $display("Streamed %0d image words and checked %0d verdicts over %0d register writes.",
               words_sent, verdicts_checked, csr_writes);
      $display("Error codes observed (bit per code): %b, matched verdicts: %0d.",
               codes_seen, match_count);
      if (fail_count == 0 && expected_verdicts.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
